/* rtl/hslc_pkg.sv */
// Shared types, constants and helpers for the header sync line capture block.
// Used by the top level and the front and back parts; depends on nothing else.
package hslc_pkg;

	localparam int MAX_HEADER  = 8;
	localparam int BYTE_W      = 8;
	localparam int HDR_IDX_W   = $clog2(MAX_HEADER);
	localparam int LEN_W       = 4;
	localparam int TICK_W      = 32;
	localparam int REG_ADDR_W  = 2;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

	// Input kinds carried on the slave-side tuser.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register indexes.
	localparam logic [REG_ADDR_W-1:0] REG_HEADER_BYTES  = 2'd0;
	localparam logic [REG_ADDR_W-1:0] REG_HEADER_LENGTH = 2'd1;
	localparam logic [REG_ADDR_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

	// Result kinds carried on the master-side tuser.
	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_END     = 2'd1,
		KIND_TIMEOUT = 2'd2
	} kind_t;

	typedef logic [MAX_HEADER-1:0][BYTE_W-1:0] header_t;

	typedef struct packed {
		header_t             header;
		logic [LEN_W-1:0]    length;
		logic [TICK_W-1:0]   timeout;
	} cfg_t;

	// One queued job: an optional single leading result, then an optional
	// burst of header bytes.
	typedef struct packed {
		logic               lead_valid;
		kind_t              lead_kind;
		logic [BYTE_W-1:0]  lead_byte;
		logic               burst;
		logic [LEN_W-1:0]   burst_len;
	} job_t;

	// Header length in use: zero acts as one, anything above the maximum
	// acts as the maximum.
	function automatic logic [LEN_W-1:0] effective_length(input logic [LEN_W-1:0] n);
		logic [LEN_W-1:0] r;
		r = n;
		if (n == '0) begin
			r = LEN_W'(1);
		end else if (n > LEN_W'(MAX_HEADER)) begin
			r = LEN_W'(MAX_HEADER);
		end
		return r;
	endfunction

endpackage

/* rtl/header_sync_line_capture.sv */
// Top level of the header sync line capture block: configuration registers,
// front part, job queue and back part. Depends on hslc_pkg, hslc_front,
// hslc_queue and hslc_back.
//
// The block accepts one input transfer (a byte or a time tick) per cycle
// while its job queue has room. Each input makes one job; a job gives one
// result per cycle at the output register while m_tready is high, except a
// completed header, which gives its header length (1 to 8) results, plus one
// leading frame end when a newline completes a one-byte header. The back
// part's one-result-per-cycle output register sets the sustained rate: a run
// of plain bytes flows at one per cycle while m_tready is high, and header
// bursts are absorbed by the QUEUE_DEPTH-entry job queue before the input
// stalls. Ticks while capturing and bytes that give no result make no job.
module header_sync_line_capture #(
	parameter int QUEUE_DEPTH = hslc_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            wr_en,
	input  logic [hslc_pkg::REG_ADDR_W-1:0] wr_index,
	input  logic [63:0]                     wr_data,
	// Input stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // data
	input  logic                            s_tuser,   // op
	// Result stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // out_byte
	output logic [1:0]                      m_tuser,   // kind
	output logic                            m_tlast
);

	hslc_pkg::header_t                 header_q;
	logic [hslc_pkg::LEN_W-1:0]        length_q;
	logic [hslc_pkg::TICK_W-1:0]       timeout_q;
	hslc_pkg::cfg_t                    cfg;

	logic                              push;
	logic                              pop;
	logic                              queue_full;
	logic                              queue_empty;
	hslc_pkg::job_t                    job_in;
	logic [$bits(hslc_pkg::job_t)-1:0] job_raw;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= '0;
			length_q  <= hslc_pkg::LEN_W'(1);
			timeout_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				hslc_pkg::REG_HEADER_BYTES: begin
					header_q <= wr_data;
				end
				hslc_pkg::REG_HEADER_LENGTH: begin
					length_q <= wr_data[hslc_pkg::LEN_W-1:0];
				end
				hslc_pkg::REG_TIMEOUT_TICKS: begin
					timeout_q <= wr_data[hslc_pkg::TICK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.header  = header_q;
	assign cfg.length  = length_q;
	assign cfg.timeout = timeout_q;

	hslc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.cfg        (cfg),
		.queue_full (queue_full),
		.push       (push),
		.job        (job_in)
	);

	hslc_queue #(
		.WIDTH ($bits(hslc_pkg::job_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (job_in),
		.pop     (pop),
		.rd_data (job_raw),
		.full    (queue_full),
		.empty   (queue_empty)
	);

	hslc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.header      (header_q),
		.queue_empty (queue_empty),
		.job         (hslc_pkg::job_t'(job_raw)),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

/* rtl/hslc_queue.sv */
// Small first-in first-out queue of jobs between the front and back parts.
// Flip-flop storage; depends on nothing else.
module hslc_queue #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DEPTH-1:0][WIDTH-1:0] mem_q;
	logic [PTR_W-1:0]            wr_ptr_q;
	logic [PTR_W-1:0]            rd_ptr_q;
	logic [CNT_W-1:0]            count_q;
	logic                        do_push;
	logic                        do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage needs no reset; only written entries are ever read.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/hslc_front.sv */
// Front part: accepts input transfers, runs the header hunt, capture and
// tick timeout state, and turns each input into at most one queued job.
// Depends on hslc_pkg.
module hslc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic                        s_tuser,
	input  logic [hslc_pkg::BYTE_W-1:0] s_tdata,
	input  hslc_pkg::cfg_t              cfg,
	input  logic                        queue_full,
	output logic                        push,
	output hslc_pkg::job_t              job
);

	logic                               capturing_q;
	logic [hslc_pkg::LEN_W-1:0]         matched_q;
	logic [hslc_pkg::TICK_W-1:0]        elapsed_q;

	logic                               capturing_d;
	logic [hslc_pkg::LEN_W-1:0]         matched_d;
	logic [hslc_pkg::TICK_W-1:0]        elapsed_d;

	logic                               accept;
	logic [hslc_pkg::LEN_W-1:0]         len;
	logic [hslc_pkg::LEN_W-1:0]         m0;
	logic [hslc_pkg::LEN_W-1:0]         hunt_start;
	logic [hslc_pkg::LEN_W-1:0]         next_match;
	logic                               hit_first;
	logic                               hit_cur;
	logic                               hit;
	logic                               complete;
	logic [hslc_pkg::TICK_W-1:0]        elapsed_inc;
	hslc_pkg::job_t                     job_d;

	assign s_tready = !queue_full;
	assign accept   = s_tvalid && s_tready;

	// Matcher: compare with the expected header byte and, after a miss
	// part-way through, once more with the first header byte.
	assign len         = hslc_pkg::effective_length(cfg.length);
	assign m0          = (matched_q >= len) ? '0 : matched_q;
	assign hit_first   = (s_tdata == cfg.header[0]);
	assign hit_cur     = (s_tdata == cfg.header[m0[hslc_pkg::HDR_IDX_W-1:0]]);
	// A newline that ends a frame is hunted from a fresh start.
	assign hunt_start  = capturing_q ? '0 : m0;
	assign hit         = capturing_q ? hit_first : hit_cur;
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		if (hit) begin
			next_match = hunt_start + 1'b1;
		end else if (hunt_start == '0) begin
			next_match = '0;
		end else begin
			next_match = hit_first ? hslc_pkg::LEN_W'(1) : '0;
		end
	end

	assign complete = (next_match == len);

	// Next state and the job for this input.
	always_comb begin
		job_d       = '0;
		capturing_d = capturing_q;
		matched_d   = matched_q;
		elapsed_d   = elapsed_q;
		if (s_tuser == hslc_pkg::OP_TICK) begin
			if (!capturing_q) begin
				elapsed_d = elapsed_inc;
				if ((cfg.timeout != '0) && (elapsed_inc >= cfg.timeout)) begin
					job_d.lead_valid = 1'b1;
					job_d.lead_kind  = hslc_pkg::KIND_TIMEOUT;
					matched_d        = '0;
					elapsed_d        = '0;
				end
			end
		end else if (capturing_q && (s_tdata != hslc_pkg::NEWLINE)) begin
			job_d.lead_valid = 1'b1;
			job_d.lead_kind  = hslc_pkg::KIND_BYTE;
			job_d.lead_byte  = s_tdata;
		end else begin
			if (capturing_q) begin
				job_d.lead_valid = 1'b1;
				job_d.lead_kind  = hslc_pkg::KIND_END;
				capturing_d      = 1'b0;
				elapsed_d        = '0;
			end
			if (complete) begin
				job_d.burst     = 1'b1;
				job_d.burst_len = len;
				capturing_d     = 1'b1;
				matched_d       = '0;
			end else begin
				matched_d = next_match;
			end
		end
	end

	assign job  = job_d;
	assign push = accept && (job_d.lead_valid || job_d.burst);

	// Block state advances on every accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capturing_q <= 1'b0;
			matched_q   <= '0;
			elapsed_q   <= '0;
		end else if (accept) begin
			capturing_q <= capturing_d;
			matched_q   <= matched_d;
			elapsed_q   <= elapsed_d;
		end
	end

endmodule

/* rtl/hslc_back.sv */
// Back part: expands queued jobs into result transfers, one per cycle
// while m_tready is high, into an output register. Depends on hslc_pkg.
module hslc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hslc_pkg::header_t           header,
	input  logic                        queue_empty,
	input  hslc_pkg::job_t              job,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [hslc_pkg::BYTE_W-1:0] m_tdata,
	output logic [1:0]                  m_tuser,
	output logic                        m_tlast
);

	logic [hslc_pkg::LEN_W-1:0]  idx_q;
	logic                        valid_q;
	logic [hslc_pkg::BYTE_W-1:0] data_q;
	hslc_pkg::kind_t             kind_q;
	logic                        last_q;

	logic                        load;
	logic                        is_lead;
	logic [hslc_pkg::LEN_W-1:0]  total;
	logic [hslc_pkg::LEN_W-1:0]  burst_pos;
	logic                        is_last;
	logic [hslc_pkg::BYTE_W-1:0] res_byte;
	hslc_pkg::kind_t             res_kind;

	assign load = !queue_empty && (!valid_q || m_tready);

	// Position inside the current job.
	assign total     = hslc_pkg::LEN_W'(job.lead_valid)
	                 + (job.burst ? job.burst_len : '0);
	assign is_lead   = job.lead_valid && (idx_q == '0);
	assign burst_pos = idx_q - hslc_pkg::LEN_W'(job.lead_valid);
	assign is_last   = (idx_q == total - 1'b1);
	assign res_byte  = is_lead ? job.lead_byte
	                           : header[burst_pos[hslc_pkg::HDR_IDX_W-1:0]];
	assign res_kind  = is_lead ? job.lead_kind : hslc_pkg::KIND_BYTE;
	assign pop       = load && is_last;

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res_byte;
			kind_q <= res_kind;
			last_q <= is_last;
		end
	end

	// Output valid and the result counter within a job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? '0 : idx_q + 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule
